// File: design/nsf_pkg.sv
package nsf_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned COUNT_W = 32;

    localparam logic [BYTE_W-1:0] MAX_BODY_LEN_RESET = 8'd82;

    localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39;
    localparam logic [BYTE_W-1:0] CH_UP_A   = 8'h41;
    localparam logic [BYTE_W-1:0] CH_UP_F   = 8'h46;
    localparam logic [BYTE_W-1:0] CH_LO_A   = 8'h61;
    localparam logic [BYTE_W-1:0] CH_LO_F   = 8'h66;
    localparam logic [BYTE_W-1:0] UP_OFFSET = 8'h37;
    localparam logic [BYTE_W-1:0] LO_OFFSET = 8'h57;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_BODY = 3'd1,
        PH_HI   = 3'd2,
        PH_LO   = 3'd3,
        PH_LF   = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        EV_NONE        = 3'd0,
        EV_OK_VERIFIED = 3'd1,
        EV_OK_PLAIN    = 3'd2,
        EV_RESTART     = 3'd3,
        EV_TOO_LONG    = 3'd4,
        EV_NON_HEX     = 3'd5,
        EV_MISMATCH    = 3'd6
    } event_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_t;

    function automatic hex_t hex_decode(input logic [BYTE_W-1:0] ch);
        hex_t              h;
        logic [BYTE_W-1:0] d;
        h = '0;
        d = '0;
        if (ch >= CH_ZERO && ch <= CH_NINE) begin
            d = ch - CH_ZERO;
            h.ok = 1'b1;
        end else if (ch >= CH_UP_A && ch <= CH_UP_F) begin
            d = ch - UP_OFFSET;
            h.ok = 1'b1;
        end else if (ch >= CH_LO_A && ch <= CH_LO_F) begin
            d = ch - LO_OFFSET;
            h.ok = 1'b1;
        end
        h.val = d[3:0];
        return h;
    endfunction

endpackage

// File: design/nmea_sentence_framer.sv
// NMEA 0183 sentence framer: takes one received byte per beat, hunts for '$', passes body
// bytes out as payload while keeping their running XOR, parses the two hex digits after '*'
// and closes the sentence on LF, reporting one result beat per input beat with the sentence
// event and saturating good and discarded counts. Throughput is one byte per clock; each
// result appears in the output register in the cycle after its byte is taken, and the input
// keeps flowing while that register is being drained, stalling only when a held result is
// not taken. max_body_length is written through cfg_we/cfg_wdata and resets to 82.
module nmea_sentence_framer (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [nsf_pkg::BYTE_W-1:0]    cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [nsf_pkg::BYTE_W-1:0]    s_rx_byte,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_payload_valid,
    output logic [nsf_pkg::BYTE_W-1:0]    m_payload_byte,
    output logic                          m_sentence_start,
    output logic [2:0]                    m_event_res,
    output logic [nsf_pkg::BYTE_W-1:0]    m_body_length,
    output logic [nsf_pkg::BYTE_W-1:0]    m_computed_checksum,
    output logic [nsf_pkg::BYTE_W-1:0]    m_parsed_checksum,
    output logic                          m_checksum_seen,
    output logic [nsf_pkg::COUNT_W-1:0]   m_decoded_total,
    output logic [nsf_pkg::COUNT_W-1:0]   m_discarded_total
);
    import nsf_pkg::*;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    logic                accept;
    logic [BYTE_W-1:0]   max_len_reg;

    phase_t              phase_reg, phase_next;
    logic [BYTE_W-1:0]   len_reg, len_next;
    logic [BYTE_W-1:0]   xor_reg, xor_next;
    logic [BYTE_W-1:0]   hi_char_reg, hi_char_next;
    logic [BYTE_W-1:0]   parsed_reg, parsed_next;
    logic                has_cks_reg, has_cks_next;
    logic [COUNT_W-1:0]  good_reg, good_next;
    logic [COUNT_W-1:0]  bad_reg, bad_next;

    logic                pv, start, snap, clr, good_inc, bad_inc;
    logic [BYTE_W-1:0]   pb;
    event_t              ev;
    hex_t                hex_hi, hex_lo;

    logic                m_valid_reg;
    logic                pv_reg, start_reg, seen_reg;
    logic [BYTE_W-1:0]   pb_reg, blen_reg, cks_reg, rcks_reg;
    event_t              ev_reg;
    logic [COUNT_W-1:0]  dec_reg, disc_reg;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= MAX_BODY_LEN_RESET;
        end else if (cfg_we) begin
            max_len_reg <= cfg_wdata;
        end
    end

    assign hex_hi = hex_decode(hi_char_reg);
    assign hex_lo = hex_decode(s_rx_byte);

    always_comb begin
        phase_next   = phase_reg;
        len_next     = len_reg;
        xor_next     = xor_reg;
        hi_char_next = hi_char_reg;
        parsed_next  = parsed_reg;
        has_cks_next = has_cks_reg;
        pv           = 1'b0;
        pb           = '0;
        start        = 1'b0;
        snap         = 1'b0;
        clr          = 1'b0;
        good_inc     = 1'b0;
        bad_inc      = 1'b0;
        ev           = EV_NONE;

        unique case (phase_reg)
            PH_BODY: begin
                if (s_rx_byte == CH_DOLLAR) begin
                    snap    = 1'b1;
                    ev      = EV_RESTART;
                    bad_inc = 1'b1;
                    clr     = 1'b1;
                    start   = 1'b1;
                end else if (s_rx_byte == CH_STAR) begin
                    has_cks_next = 1'b1;
                    phase_next   = PH_HI;
                end else if (s_rx_byte == CH_CR) begin
                    has_cks_next = 1'b0;
                    phase_next   = PH_LF;
                end else if (s_rx_byte == CH_LF) begin
                    snap     = 1'b1;
                    ev       = EV_OK_PLAIN;
                    good_inc = 1'b1;
                    clr      = 1'b1;
                end else if (len_reg >= max_len_reg) begin
                    snap    = 1'b1;
                    ev      = EV_TOO_LONG;
                    bad_inc = 1'b1;
                    clr     = 1'b1;
                end else begin
                    pv       = 1'b1;
                    pb       = s_rx_byte;
                    len_next = len_reg + 8'd1;
                    xor_next = xor_reg ^ s_rx_byte;
                end
            end
            PH_HI: begin
                hi_char_next = s_rx_byte;
                phase_next   = PH_LO;
            end
            PH_LO: begin
                if (hex_hi.ok && hex_lo.ok) begin
                    parsed_next = {hex_hi.val, hex_lo.val};
                    phase_next  = PH_LF;
                end else begin
                    snap    = 1'b1;
                    ev      = EV_NON_HEX;
                    bad_inc = 1'b1;
                    clr     = 1'b1;
                end
            end
            PH_LF: begin
                if (s_rx_byte == CH_LF) begin
                    snap = 1'b1;
                    clr  = 1'b1;
                    if (has_cks_reg && xor_reg != parsed_reg) begin
                        ev      = EV_MISMATCH;
                        bad_inc = 1'b1;
                    end else begin
                        ev       = has_cks_reg ? EV_OK_VERIFIED : EV_OK_PLAIN;
                        good_inc = 1'b1;
                    end
                end else if (s_rx_byte == CH_DOLLAR) begin
                    snap    = 1'b1;
                    ev      = EV_RESTART;
                    bad_inc = 1'b1;
                    clr     = 1'b1;
                    start   = 1'b1;
                end
            end
            default: begin
                // hunting, and any code that means nothing
                if (s_rx_byte == CH_DOLLAR) begin
                    clr   = 1'b1;
                    start = 1'b1;
                end
            end
        endcase

        if (clr) begin
            phase_next   = PH_HUNT;
            len_next     = '0;
            xor_next     = '0;
            hi_char_next = '0;
            parsed_next  = '0;
            has_cks_next = 1'b0;
        end
        if (start) begin
            phase_next = PH_BODY;
        end

        good_next = (good_inc && good_reg != COUNT_MAX) ? good_reg + 32'd1 : good_reg;
        bad_next  = (bad_inc && bad_reg != COUNT_MAX) ? bad_reg + 32'd1 : bad_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HUNT;
            len_reg     <= '0;
            xor_reg     <= '0;
            hi_char_reg <= '0;
            parsed_reg  <= '0;
            has_cks_reg <= 1'b0;
            good_reg    <= '0;
            bad_reg     <= '0;
        end else if (accept) begin
            phase_reg   <= phase_next;
            len_reg     <= len_next;
            xor_reg     <= xor_next;
            hi_char_reg <= hi_char_next;
            parsed_reg  <= parsed_next;
            has_cks_reg <= has_cks_next;
            good_reg    <= good_next;
            bad_reg     <= bad_next;
        end
    end

    // result register; a sentence-ending event shows the sentence before it is cleared
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pv_reg    <= pv;
            pb_reg    <= pb;
            start_reg <= start;
            ev_reg    <= ev;
            blen_reg  <= snap ? len_reg : len_next;
            cks_reg   <= snap ? xor_reg : xor_next;
            rcks_reg  <= snap ? parsed_reg : parsed_next;
            seen_reg  <= snap ? has_cks_reg : has_cks_next;
            dec_reg   <= good_next;
            disc_reg  <= bad_next;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_payload_valid     = pv_reg;
    assign m_payload_byte      = pb_reg;
    assign m_sentence_start    = start_reg;
    assign m_event_res         = ev_reg;
    assign m_body_length       = blen_reg;
    assign m_computed_checksum = cks_reg;
    assign m_parsed_checksum   = rcks_reg;
    assign m_checksum_seen     = seen_reg;
    assign m_decoded_total     = dec_reg;
    assign m_discarded_total   = disc_reg;

    a_good_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> good_reg >= $past(good_reg))
        else $error("good count went down");

    a_bad_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> bad_reg >= $past(bad_reg))
        else $error("discard count went down");

    a_payload_no_event: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && pv_reg |-> ev_reg == EV_NONE)
        else $error("payload beat carries an event");

    a_start_enters_body: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && start |=> phase_reg == PH_BODY)
        else $error("sentence start did not enter body");

    a_end_returns_hunt: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && ev != EV_NONE && ev != EV_RESTART |=> phase_reg == PH_HUNT && len_reg == '0)
        else $error("ended sentence not cleared");

endmodule

// File: dv/tb.sv
module tb;
    import nsf_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;

    typedef logic [BYTE_W-1:0] byte_t;

    typedef struct packed {
        logic                 pv;
        byte_t                pb;
        logic                 start;
        event_t               ev;
        byte_t                len;
        byte_t                csum;
        byte_t                rx_sum;
        logic                 seen;
        logic [COUNT_W-1:0]   good;
        logic [COUNT_W-1:0]   bad;
    } framer_out_t;

    typedef enum int {
        TAIL_OK,
        TAIL_PLAIN,
        TAIL_BAD_SUM,
        TAIL_BAD_HI,
        TAIL_BAD_LO,
        TAIL_RESTART,
        TAIL_LF_RESTART
    } tail_t;

    logic               aclk;
    logic               aresetn;
    logic               cfg_we;
    byte_t              cfg_wdata;
    logic               s_valid;
    logic               s_ready;
    byte_t              s_rx_byte;
    logic               m_valid;
    logic               m_ready;
    logic               m_payload_valid;
    byte_t              m_payload_byte;
    logic               m_sentence_start;
    logic [2:0]         m_event_res;
    byte_t              m_body_length;
    byte_t              m_computed_checksum;
    byte_t              m_parsed_checksum;
    logic               m_checksum_seen;
    logic [COUNT_W-1:0] m_decoded_total;
    logic [COUNT_W-1:0] m_discarded_total;

    nmea_sentence_framer i_dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_we              (cfg_we),
        .cfg_wdata           (cfg_wdata),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_rx_byte           (s_rx_byte),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_payload_valid     (m_payload_valid),
        .m_payload_byte      (m_payload_byte),
        .m_sentence_start    (m_sentence_start),
        .m_event_res         (m_event_res),
        .m_body_length       (m_body_length),
        .m_computed_checksum (m_computed_checksum),
        .m_parsed_checksum   (m_parsed_checksum),
        .m_checksum_seen     (m_checksum_seen),
        .m_decoded_total     (m_decoded_total),
        .m_discarded_total   (m_discarded_total)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // framer state as the testbench sees it
    byte_t              body_limit = MAX_BODY_LEN_RESET;
    phase_t             pr_phase   = PH_HUNT;
    byte_t              pr_len     = '0;
    byte_t              pr_xor     = '0;
    byte_t              pr_hi_char = '0;
    byte_t              pr_rx_sum  = '0;
    logic               pr_has_sum = 1'b0;
    logic [COUNT_W-1:0] good_cnt   = '0;
    logic [COUNT_W-1:0] bad_cnt    = '0;

    framer_out_t frame_results_q[$];
    int          errors       = 0;
    int          sent_count   = 0;
    int          quiet_cycles = 0;
    int          hold_left    = 0;
    int          stall_left   = 0;
    bit          tx_idle      = 1'b1;
    bit          rx_idle      = 1'b1;

    function automatic void clear_sentence();
        pr_phase   = PH_HUNT;
        pr_len     = '0;
        pr_xor     = '0;
        pr_hi_char = '0;
        pr_rx_sum  = '0;
        pr_has_sum = 1'b0;
    endfunction

    function automatic void bump_good();
        if (good_cnt != '1) good_cnt++;
    endfunction

    function automatic void bump_bad();
        if (bad_cnt != '1) bad_cnt++;
    endfunction

    function automatic bit hex_nibble(input byte_t ch, output logic [3:0] v);
        v = ch[3:0];
        if (ch >= CH_ZERO && ch <= CH_NINE) return 1'b1;
        v = ch[3:0] + 4'd9;
        return (ch >= CH_UP_A && ch <= CH_UP_F) || (ch >= CH_LO_A && ch <= CH_LO_F);
    endfunction

    function automatic framer_out_t with_sentence(input framer_out_t o);
        o.len    = pr_len;
        o.csum   = pr_xor;
        o.rx_sum = pr_rx_sum;
        o.seen   = pr_has_sum;
        return o;
    endfunction

    // a '$' inside an open sentence discards it and opens a new one at once
    function automatic framer_out_t restart_sentence(input framer_out_t o);
        o       = with_sentence(o);
        o.ev    = EV_RESTART;
        bump_bad();
        clear_sentence();
        pr_phase = PH_BODY;
        o.start = 1'b1;
        return o;
    endfunction

    function automatic framer_out_t predict_byte(input byte_t c);
        framer_out_t o;
        logic [3:0]  hi_v;
        logic [3:0]  lo_v;
        o    = '0;
        o.ev = EV_NONE;
        case (pr_phase)
            PH_BODY: begin
                if (c == CH_DOLLAR) begin
                    o = restart_sentence(o);
                end else if (c == CH_STAR) begin
                    pr_has_sum = 1'b1;
                    pr_phase   = PH_HI;
                end else if (c == CH_CR) begin
                    pr_has_sum = 1'b0;
                    pr_phase   = PH_LF;
                end else if (c == CH_LF) begin
                    pr_has_sum = 1'b0;
                    o    = with_sentence(o);
                    o.ev = EV_OK_PLAIN;
                    bump_good();
                    clear_sentence();
                end else if (pr_len >= body_limit) begin
                    o    = with_sentence(o);
                    o.ev = EV_TOO_LONG;
                    bump_bad();
                    clear_sentence();
                end else begin
                    o.pv   = 1'b1;
                    o.pb   = c;
                    pr_len = pr_len + 8'd1;
                    pr_xor = pr_xor ^ c;
                end
            end
            PH_HI: begin
                pr_hi_char = c;
                pr_phase   = PH_LO;
            end
            PH_LO: begin
                if (hex_nibble(pr_hi_char, hi_v) && hex_nibble(c, lo_v)) begin
                    pr_rx_sum = {hi_v, lo_v};
                    pr_phase  = PH_LF;
                end else begin
                    o    = with_sentence(o);
                    o.ev = EV_NON_HEX;
                    bump_bad();
                    clear_sentence();
                end
            end
            PH_LF: begin
                if (c == CH_LF) begin
                    o = with_sentence(o);
                    if (pr_has_sum && pr_xor != pr_rx_sum) begin
                        o.ev = EV_MISMATCH;
                        bump_bad();
                    end else begin
                        o.ev = pr_has_sum ? EV_OK_VERIFIED : EV_OK_PLAIN;
                        bump_good();
                    end
                    clear_sentence();
                end else if (c == CH_DOLLAR) begin
                    o = restart_sentence(o);
                end
            end
            default: begin
                if (c == CH_DOLLAR) begin
                    clear_sentence();
                    pr_phase = PH_BODY;
                    o.start  = 1'b1;
                end
            end
        endcase
        // every event reports the sentence it closed; otherwise show the state after the byte
        if (o.ev == EV_NONE) o = with_sentence(o);
        o.good = good_cnt;
        o.bad  = bad_cnt;
        return o;
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin : result_check
        framer_out_t want;
        if (aresetn) begin
            if (s_valid && s_ready) frame_results_q.push_back(predict_byte(s_rx_byte));
            if (m_valid && m_ready) begin
                if (frame_results_q.size() == 0) begin
                    $display("%0t: result beat with nothing expected", $time);
                    errors++;
                end else begin
                    want = frame_results_q.pop_front();
                    compare_field("payload_valid", 32'(want.pv), 32'(m_payload_valid));
                    compare_field("payload_byte", 32'(want.pb), 32'(m_payload_byte));
                    compare_field("sentence_start", 32'(want.start), 32'(m_sentence_start));
                    compare_field("event_res", 32'(want.ev), 32'(m_event_res));
                    compare_field("body_length", 32'(want.len), 32'(m_body_length));
                    compare_field("computed_checksum", 32'(want.csum),
                                  32'(m_computed_checksum));
                    compare_field("parsed_checksum", 32'(want.rx_sum), 32'(m_parsed_checksum));
                    compare_field("checksum_seen", 32'(want.seen), 32'(m_checksum_seen));
                    compare_field("decoded_total", want.good, m_decoded_total);
                    compare_field("discarded_total", want.bad, m_discarded_total);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 94) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // result side: long hold-off first, then random stalls
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_ready = 1'b0;
            hold_left--;
        end else if (stall_left > 0) begin
            m_ready = 1'b0;
            stall_left--;
        end else if (rx_idle && $urandom_range(0, 3) == 0) begin
            m_ready    = 1'b0;
            stall_left = pick_gap() - 1;
        end else begin
            m_ready = 1'b1;
        end
    end

    task automatic send_byte(input byte_t b);
        int gap;
        gap = 0;
        if (tx_idle && $urandom_range(0, 2) == 0) gap = pick_gap();
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   = 1'b1;
        s_rx_byte = b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent_count++;
        @(negedge aclk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(byte_t'(s[i]));
    endtask

    task automatic wait_results_done();
        s_valid = 1'b0;
        while (frame_results_q.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic set_body_limit(input byte_t v);
        wait_results_done();
        cfg_wdata = v;
        cfg_we    = 1'b1;
        @(negedge aclk);
        cfg_we     = 1'b0;
        body_limit = v;
    endtask

    function automatic byte_t hex_char(input logic [3:0] n, input bit upper);
        if (n < 4'd10) return CH_ZERO + byte_t'(n);
        return (upper ? CH_UP_A : CH_LO_A) + byte_t'(n) - 8'd10;
    endfunction

    function automatic byte_t non_hex();
        byte_t      c;
        logic [3:0] v;
        do c = byte_t'($urandom_range(0, 255)); while (hex_nibble(c, v));
        return c;
    endfunction

    task automatic send_checksum(input byte_t sum);
        send_byte(CH_STAR);
        send_byte(hex_char(sum[7:4], 1'($urandom_range(0, 1))));
        send_byte(hex_char(sum[3:0], 1'($urandom_range(0, 1))));
    endtask

    // CR LF, bare LF, or CR with junk before the LF
    task automatic send_end();
        byte_t c;
        int    pick;
        pick = $urandom_range(0, 2);
        if (pick != 1) send_byte(CH_CR);
        if (pick == 2) begin
            repeat ($urandom_range(1, 3)) begin
                do c = byte_t'($urandom_range(0, 255)); while (c == CH_DOLLAR || c == CH_LF);
                send_byte(c);
            end
        end
        send_byte(CH_LF);
    endtask

    task automatic send_sentence(input int len, input tail_t tail);
        byte_t c;
        byte_t x;
        x = '0;
        send_byte(CH_DOLLAR);
        for (int i = 0; i < len; i++) begin
            do begin
                if ($urandom_range(0, 3) != 0) c = byte_t'($urandom_range(8'h20, 8'h7E));
                else c = byte_t'($urandom_range(0, 255));
            end while (c == CH_DOLLAR || c == CH_STAR || c == CH_CR || c == CH_LF);
            x = x ^ c;
            send_byte(c);
        end
        case (tail)
            TAIL_OK: begin
                send_checksum(x);
                send_end();
            end
            TAIL_PLAIN: send_end();
            TAIL_BAD_SUM: begin
                send_checksum(x ^ byte_t'($urandom_range(1, 255)));
                send_end();
            end
            TAIL_BAD_HI: begin
                send_byte(CH_STAR);
                send_byte(non_hex());
                send_byte(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
            end
            TAIL_BAD_LO: begin
                send_byte(CH_STAR);
                send_byte(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
                send_byte(non_hex());
            end
            TAIL_RESTART: send_byte(CH_DOLLAR);
            default: begin
                send_byte(CH_CR);
                send_byte(CH_DOLLAR);
            end
        endcase
    endtask

    task automatic test_directed();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CH_STAR);
        send_byte(CH_LF);
        send_text("$A*41");
        send_byte(CH_CR);
        send_byte(CH_LF);
        send_text("$J*4a");
        send_byte(CH_LF);
        send_text("$");
        send_byte(CH_LF);
        send_text("$B*00");
        send_byte(CH_LF);
        // restart in the body, then a bad first digit
        send_text("$C$D*G0");
        // a '$' is taken as a checksum digit and fails
        send_text("$E*4$");
        // restart while waiting for LF, then a plain sentence closed by CR LF
        send_text("$*00");
        send_byte(CH_CR);
        send_text("$F");
        send_byte(CH_CR);
        send_byte(CH_LF);
        wait_results_done();
    endtask

    task automatic test_body_limits();
        set_body_limit(8'd1);
        send_text("$AB");
        send_byte(CH_LF);
        send_text("$Z");
        send_byte(CH_LF);
        set_body_limit(8'd255);
        send_sentence(255, TAIL_PLAIN);
        send_sentence(256, TAIL_OK);
        set_body_limit(MAX_BODY_LEN_RESET);
    endtask

    task automatic test_random_framing(input int bytes_goal);
        int    first;
        int    cap;
        int    len;
        int    r;
        tail_t tail;
        first = sent_count;
        cap   = body_limit + 2;
        while (sent_count - first < bytes_goal) begin
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            // line noise between sentences, kept below '$'
            if ($urandom_range(0, 7) == 0)
                repeat ($urandom_range(1, 3)) send_byte(byte_t'($urandom_range(0, 8'h23)));
            if ($urandom_range(0, 9) < 8) len = $urandom_range(0, cap < 16 ? cap : 16);
            else len = $urandom_range(0, cap);
            r = $urandom_range(0, 99);
            if (r < 35) tail = TAIL_OK;
            else if (r < 55) tail = TAIL_PLAIN;
            else if (r < 70) tail = TAIL_BAD_SUM;
            else if (r < 78) tail = TAIL_BAD_HI;
            else if (r < 86) tail = TAIL_BAD_LO;
            else if (r < 93) tail = TAIL_RESTART;
            else tail = TAIL_LF_RESTART;
            send_sentence(len, tail);
        end
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    task automatic test_backpressure();
        wait_results_done();
        tx_idle   = 1'b0;
        rx_idle   = 1'b0;
        hold_left = HOLD_CYCLES;
        repeat (3) send_sentence(12, TAIL_OK);
        wait_results_done();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    task automatic test_noise(input int n);
        int r;
        repeat (n) begin
            r = $urandom_range(0, 9);
            if (r == 0) send_byte(CH_DOLLAR);
            else if (r == 1) send_byte(CH_STAR);
            else if (r == 2) send_byte(CH_CR);
            else if (r == 3) send_byte(CH_LF);
            else if (r == 4)
                send_byte(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
            else send_byte(byte_t'($urandom_range(0, 255)));
        end
        wait_results_done();
    endtask

    initial begin
        aclk      = 1'b0;
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        s_valid   = 1'b0;
        s_rx_byte = '0;
        m_ready   = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        test_body_limits();
        test_random_framing(400);
        set_body_limit(byte_t'($urandom_range(2, 30)));
        test_random_framing(300);
        test_backpressure();
        test_noise(200);
        set_body_limit(8'd255);
        test_random_framing(180);
        set_body_limit(MAX_BODY_LEN_RESET);
        test_random_framing(100);
        wait_results_done();

        if (errors == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

endmodule
